[design/kbcp_pkg.sv]
// Shared types, widths and constant tables of the keyed byte-to-character-pair encoder.
`timescale 1ns / 1ps

package kbcp_pkg;

   localparam int KEY_DEPTH_DEFAULT = 8;
   localparam int KEY_WORD_WIDTH    = 64;
   localparam int KEY_LEN_WIDTH     = 4;
   localparam int KEY_POS_WIDTH     = 3;
   localparam int DATA_WIDTH        = 8;
   localparam int CHAR_WIDTH        = 7;
   localparam int QUEUE_DEPTH       = 2;

   // CSR map: one 64-bit register every 8 bytes, decoded on address bit 3
   localparam int           CSR_ADDR_WIDTH = 4;
   localparam int           CSR_DATA_WIDTH = 64;
   localparam logic         CSR_SEL_KEY    = 1'b0;
   localparam logic         CSR_SEL_LENGTH = 1'b1;

   // spread code words, indexed by (key byte + bit number) mod 8
   localparam logic [15:0] CODE_WORDS [8] = '{
      16'h0008, 16'h0804, 16'h0400, 16'h0001,
      16'h0010, 16'h0200, 16'h1100, 16'h0002
   };

   // output alphabet, ASCII codes
   localparam logic [CHAR_WIDTH-1:0] ALPHABET [32] = '{
      7'h48, 7'h4A, 7'h34, 7'h38, 7'h43, 7'h4B, 7'h50, 7'h39,
      7'h41, 7'h57, 7'h42, 7'h52, 7'h53, 7'h44, 7'h54, 7'h33,
      7'h4D, 7'h59, 7'h4C, 7'h51, 7'h30, 7'h46, 7'h47, 7'h31,
      7'h4E, 7'h55, 7'h45, 7'h37, 7'h58, 7'h35, 7'h36, 7'h32
   };

   // one classified word waiting between front and back
   typedef struct packed {
      logic [DATA_WIDTH-1:0]    sum;
      logic [KEY_POS_WIDTH-1:0] rot;
      logic                     last;
      logic                     missing;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

endpackage

[design/kbcp_if.sv]
// Word channel interfaces: raw data bytes in, character pairs out.
`timescale 1ns / 1ps

interface kbcp_req_if;
   logic                             valid;
   logic                             ready;
   logic [kbcp_pkg::DATA_WIDTH-1:0]  data_byte;
   logic                             first_byte;
   logic                             last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface kbcp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [kbcp_pkg::CHAR_WIDTH-1:0]  char_first;
   logic [kbcp_pkg::CHAR_WIDTH-1:0]  char_second;
   logic                             end_of_message;
   logic                             key_missing;

   modport source (output valid, char_first, char_second, end_of_message, key_missing,
                   input ready);
   modport sink   (input valid, char_first, char_second, end_of_message, key_missing,
                   output ready);
endinterface

[design/kbcp_fifo.sv]
// Short word queue between the front and back stages.
`timescale 1ns / 1ps

module kbcp_fifo #(
   parameter int WIDTH = kbcp_pkg::ENTRY_WIDTH,
   parameter int DEPTH = kbcp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT  = CNT_WIDTH'(DEPTH);

   logic [WIDTH-1:0]     slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   // occupancy never runs past the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count overflow");
`endif

endmodule

[design/kbcp_front.sv]
// Front stage: accepts data words, tracks key position, picks the key byte, adds it.
`timescale 1ns / 1ps

module kbcp_front #(
   parameter int KEY_DEPTH = kbcp_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [kbcp_pkg::KEY_WORD_WIDTH-1:0]   key_word,
   input  logic [kbcp_pkg::KEY_LEN_WIDTH-1:0]    key_length,
   kbcp_req_if.sink                              req_chan,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output kbcp_pkg::entry_type                   push_entry
);

   import kbcp_pkg::*;

   localparam logic [KEY_LEN_WIDTH-1:0] DEPTH_LEN = KEY_LEN_WIDTH'(KEY_DEPTH);

   logic [KEY_POS_WIDTH-1:0] pos_ff, pos_in;
   logic [KEY_LEN_WIDTH-1:0] len_used;
   logic [KEY_POS_WIDTH-1:0] pos_req, pos_sel;
   logic [KEY_LEN_WIDTH-1:0] pos_inc;
   logic [DATA_WIDTH-1:0]    key_byte;
   logic                     missing;
   logic                     accept;

   assign len_used = (key_length > DEPTH_LEN) ? DEPTH_LEN : key_length;
   assign missing  = (len_used == '0);
   // stale position (length lowered mid-message) falls back to key byte 0
   assign pos_req  = req_chan.first_byte ? '0 : pos_ff;
   assign pos_sel  = ({1'b0, pos_req} >= len_used) ? '0 : pos_req;
   assign pos_inc  = {1'b0, pos_sel} + KEY_LEN_WIDTH'(1);
   assign key_byte = key_word[pos_sel*DATA_WIDTH +: DATA_WIDTH];

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   always_comb begin
      push_entry.sum     = req_chan.data_byte + key_byte;
      push_entry.rot     = key_byte[KEY_POS_WIDTH-1:0];
      push_entry.last    = req_chan.last_byte;
      push_entry.missing = missing;
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (missing || pos_inc >= len_used) begin
            pos_in = '0;
         end else begin
            pos_in = pos_inc[KEY_POS_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

`ifndef SYNTH
   a_pos_in_key: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < DEPTH_LEN) else $error("key position beyond key depth");

   a_missing_clears: assert property (@(posedge clock) disable iff (reset)
      accept && missing |=> pos_ff == '0) else $error("position kept without key");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.first_byte && len_used > KEY_LEN_WIDTH'(1)
      |=> pos_ff == KEY_POS_WIDTH'(1)) else $error("first word did not restart key");
`endif

endmodule

[design/kbcp_back.sv]
// Back stage: spreads the keyed sum over the code words and looks up both characters.
`timescale 1ns / 1ps

module kbcp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  kbcp_pkg::entry_type pop_entry,
   kbcp_rsp_if.source          rsp_chan
);

   import kbcp_pkg::*;

   logic                  valid_ff;
   logic [CHAR_WIDTH-1:0] first_ff, second_ff;
   logic                  last_ff, missing_ff;
   logic [15:0]           pattern;
   logic [CHAR_WIDTH-1:0] first_in, second_in;
   logic                  load;

   always_comb begin
      pattern = '0;
      for (int j = 0; j < 8; j++) begin
         if (pop_entry.sum[j]) begin
            pattern = pattern | CODE_WORDS[pop_entry.rot + KEY_POS_WIDTH'(j)];
         end
      end
   end

   assign first_in  = pop_entry.missing ? '0 : ALPHABET[pattern[4:0]];
   assign second_in = pop_entry.missing ? '0 : ALPHABET[pattern[12:8]];

   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign load      = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         first_ff   <= first_in;
         second_ff  <= second_in;
         last_ff    <= pop_entry.last;
         missing_ff <= pop_entry.missing;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.char_first     = first_ff;
   assign rsp_chan.char_second    = second_ff;
   assign rsp_chan.end_of_message = last_ff;
   assign rsp_chan.key_missing    = missing_ff;

`ifndef SYNTH
   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && missing_ff |-> first_ff == '0 && second_ff == '0)
      else $error("characters not cleared without key");
`endif

endmodule

[design/keyed_byte_to_char_pair_encoder.sv]
// Top level of the keyed byte-to-character-pair encoder: CSRs, front, queue, back.
`timescale 1ns / 1ps

// channel   dir  handshake        word
// req_chan  in   valid/ready      data_byte, first_byte, last_byte
// rsp_chan  out  valid/ready      char_first, char_second, end_of_message, key_missing
// csr_*     in   APB write/read   key_bytes @0x0 (64b), key_length @0x8 (4b)
//
// One word per cycle sustained while rsp_chan is ready; a result is offered once its word
// has been taken and registered in the queue, then in the output register.
// The only feedback is the 3-bit key position in the front, updated at each accept.
// A two-word queue sits between front and back, and the back holds its result in
// an output register, so rsp stalls reach req only once the queue fills.
// Synchronous active-high reset clears the key, the key length and the position.

module keyed_byte_to_char_pair_encoder #(
   parameter int KEY_DEPTH = kbcp_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   kbcp_req_if.sink                             req_chan,
   kbcp_rsp_if.source                           rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [kbcp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [kbcp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [kbcp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   import kbcp_pkg::*;

   localparam int KEY_BITS = KEY_DEPTH * DATA_WIDTH;

   // only the key bytes that can ever be in use are stored
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [KEY_LEN_WIDTH-1:0]  len_ff, len_in;
   logic [KEY_WORD_WIDTH-1:0] key_word;
   logic                      csr_wr;
   logic                      csr_sel;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;
   logic [ENTRY_WIDTH-1:0] pop_bits;

   // ---- CSR block: registers decoded on address bit 3, no wait states
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_word               = '0;
      key_word[KEY_BITS-1:0] = key_ff;
   end

   always_comb begin
      key_in = key_ff;
      len_in = len_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            CSR_SEL_KEY:    key_in = csr_pwdata[KEY_BITS-1:0];
            CSR_SEL_LENGTH: len_in = csr_pwdata[KEY_LEN_WIDTH-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_SEL_KEY:    csr_prdata = key_word;
         CSR_SEL_LENGTH: csr_prdata = CSR_DATA_WIDTH'(len_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         len_ff <= '0;
      end else begin
         key_ff <= key_in;
         len_ff <= len_in;
      end
   end

   // ---- front: key position, key byte select, keyed add
   kbcp_front #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .key_word   (key_word),
      .key_length (len_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // ---- queue between front and back
   kbcp_fifo #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_bits)
   );

   assign pop_entry = entry_type'(pop_bits);

   // ---- back: spread pattern, alphabet lookup, output register
   kbcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   a_len_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_sel == CSR_SEL_LENGTH |=> len_ff == $past(csr_pwdata[KEY_LEN_WIDTH-1:0]))
      else $error("key length write lost");
`endif

endmodule
